// File: hdl/scc_pkg.sv
// Shared constants, operation codes and controller states of the stack calculator core.
// No dependencies; used by stack_calculator_core_unit and tb_top.
package scc_pkg;

  localparam int unsigned STACK_DEPTH   = 16;
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned KEY_BITS      = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned NAME_W  = 16;
  localparam int unsigned DEPTH_W = 5;

  // stack pointer holds 0..STACK_DEPTH, stack address 0..STACK_DEPTH-1
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 4'd0,
    MODE_ADD    = 4'd1,
    MODE_SUB    = 4'd2,
    MODE_MUL    = 4'd3,
    MODE_WRITE  = 4'd4,
    MODE_READ   = 4'd5,
    MODE_JUMP   = 4'd6,
    MODE_JUMPZ  = 4'd7,
    MODE_ASSIGN = 4'd8,
    MODE_QUERY  = 4'd9
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALU,
    ST_ARITH_WB,
    ST_SEARCH,
    ST_HIT,
    ST_TOP_LOAD,
    ST_PUSH_VAR,
    ST_QUERY,
    ST_DONE
  } state_e;

endpackage

// File: hdl/scc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module scc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/stack_calculator_core_unit.sv
// Top level of the stack calculator core: controller, stack and variable table.
// Depends on scc_pkg and scc_ram.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one instruction word: mode_i,
//   name_key_i, operand_i. Output channel (out_valid_o/out_ready_i) returns
//   exactly one result word per instruction, in order.
//   The block works on one instruction at a time. in_ready_o is high while the
//   controller is idle, also while a finished result still waits in the output
//   register; a stalled receiver only holds the next instruction at the end of
//   its execution, until the output register is free.
//   States from acceptance to the registered result:
//     push, jump, jumpz, modes 10..15: EXEC, DONE
//     add, sub, mul: EXEC, ALU, ARITH_WB, DONE; on an empty stack EXEC, DONE
//     write, read, assign, query: EXEC, SEARCH, HIT, [TOP_LOAD|PUSH_VAR|QUERY], DONE
//   The next word is taken in IDLE, which DONE enters once the result is registered.
//   Lookups dominate: the table memory has one read port, so the search walks the
//   table one entry per cycle.
//   Reset clears the stack pointer, the table valid bits and the output valid flag.
//   Stack and table memories are not cleared; valid bits and the stack pointer
//   hide stale entries, so no clearing pass is needed.
module stack_calculator_core_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [scc_pkg::MODE_W-1:0]    mode_i,
  input  logic        [scc_pkg::NAME_W-1:0]    name_key_i,
  input  logic signed [scc_pkg::DATA_W-1:0]    operand_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [scc_pkg::DATA_W-1:0]    top_value_o,
  output logic        [scc_pkg::DEPTH_W-1:0]   depth_now_o,
  output logic signed [scc_pkg::DATA_W-1:0]    query_value_o,
  output logic                                 call_request_o,
  output logic        [scc_pkg::NAME_W-1:0]    call_target_o,
  output logic                                 overflow_flag_o
);

  localparam int unsigned DW    = scc_pkg::DATA_W;
  localparam int unsigned SP_W  = scc_pkg::SP_W;
  localparam int unsigned SA_W  = scc_pkg::SA_W;
  localparam int unsigned IDX_W = scc_pkg::IDX_W;
  localparam int unsigned KB    = scc_pkg::KEY_BITS;
  localparam int unsigned TE    = scc_pkg::TABLE_ENTRIES;
  localparam int unsigned DEPTH_W_L = scc_pkg::DEPTH_W;

  localparam logic [SP_W-1:0]  SP_FULL  = SP_W'(scc_pkg::STACK_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TE - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  scc_pkg::state_e state_q, state_d;
  scc_pkg::mode_e  mode_q, mode_d;
  logic [KB-1:0]    key_q, key_d;
  logic [DW-1:0]    opnd_q, opnd_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [DW-1:0]    top_q, top_d;       // cached stack top, meaningful when sp_q != 0
  logic [DW-1:0]    res_q, res_d;       // arithmetic result
  logic             two_q, two_d;       // two operands on the stack
  logic [IDX_W-1:0] scan_q, scan_d;     // next table entry to read
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [TE-1:0]    valid_q, valid_d;
  logic [DW-1:0]    query_q, query_d;
  logic             call_q, call_d;
  logic             ovf_q, ovf_d;

  logic                   out_valid_q, out_valid_d;
  logic [DW-1:0]          out_top_q, out_top_d;
  logic [DEPTH_W_L-1:0]   out_depth_q, out_depth_d;
  logic [DW-1:0]          out_query_q, out_query_d;
  logic                   out_call_q, out_call_d;
  logic [scc_pkg::NAME_W-1:0] out_target_q, out_target_d;
  logic                   out_ovf_q, out_ovf_d;

  // ---------------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------------
  logic             stk_we;
  logic [SA_W-1:0]  stk_waddr, stk_raddr;
  logic [DW-1:0]    stk_wdata, stk_rdata;

  // table entry: key in the upper bits, value in the lower bits
  logic             tbl_we;
  logic             tbl_new;            // write claims a free entry
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [DW-1:0]    tbl_wval;
  logic [KB+DW-1:0] tbl_rdata;
  logic [KB-1:0]    key_rdata;
  logic [DW-1:0]    val_rdata;

  assign key_rdata = tbl_rdata[KB+DW-1:DW];
  assign val_rdata = tbl_rdata[DW-1:0];

  scc_ram #(.WIDTH(DW), .DEPTH(scc_pkg::STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  scc_ram #(.WIDTH(KB + DW), .DEPTH(TE)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i ({key_q, tbl_wval}),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // lowest free table entry, from the valid flops
  logic             free_any;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TE - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // second operand: next-of-stack when present, else 0 (1 for mul)
  logic [DW-1:0] alu_b;
  assign alu_b = two_q ? stk_rdata :
                 ((mode_q == scc_pkg::MODE_MUL) ? DW'(1) : '0);

  logic [SA_W-1:0] sp_m2;   // address of the entry below the top
  logic [SA_W-1:0] sp_lo;   // address of the first free slot
  assign sp_m2 = SA_W'(sp_q - SP_W'(2));
  assign sp_lo = SA_W'(sp_q);

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    key_d     = key_q;
    opnd_d    = opnd_q;
    sp_d      = sp_q;
    top_d     = top_q;
    res_d     = res_q;
    two_d     = two_q;
    scan_d    = scan_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmp_vld_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    valid_d   = valid_q;
    query_d   = query_q;
    call_d    = call_q;
    ovf_d     = ovf_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_query_d  = out_query_q;
    out_call_d   = out_call_q;
    out_target_d = out_target_q;
    out_ovf_d    = out_ovf_q;

    stk_we    = 1'b0;
    stk_waddr = sp_lo;
    stk_wdata = top_d;
    stk_raddr = sp_m2;
    tbl_we    = 1'b0;
    tbl_new   = 1'b0;
    tbl_waddr = hit_idx_q;
    tbl_wval  = opnd_q;
    tbl_raddr = scan_q;

    unique case (state_q)
      scc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d    = scc_pkg::mode_e'(mode_i);
          key_d     = KB'(name_key_i);
          opnd_d    = operand_i;
          query_d   = '0;
          call_d    = 1'b0;
          ovf_d     = 1'b0;
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          state_d   = scc_pkg::ST_EXEC;
        end
      end

      scc_pkg::ST_EXEC: begin
        state_d = scc_pkg::ST_DONE;
        case (mode_q)
          scc_pkg::MODE_PUSH: begin
            if (sp_q == SP_FULL) begin
              ovf_d = 1'b1;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = opnd_q;
              top_d     = opnd_q;
              sp_d      = sp_q + SP_W'(1);
            end
          end
          scc_pkg::MODE_ADD, scc_pkg::MODE_SUB, scc_pkg::MODE_MUL: begin
            if (sp_q == '0) begin
              // empty stack: push 0
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = '0;
              top_d     = '0;
              sp_d      = SP_W'(1);
            end else begin
              two_d   = (sp_q > SP_W'(1));
              state_d = scc_pkg::ST_ALU;   // next-of-stack read issued here
            end
          end
          scc_pkg::MODE_JUMP: begin
            call_d = 1'b1;
          end
          scc_pkg::MODE_JUMPZ: begin
            call_d = (sp_q == '0) || (top_q == '0);
          end
          scc_pkg::MODE_WRITE, scc_pkg::MODE_READ,
          scc_pkg::MODE_ASSIGN, scc_pkg::MODE_QUERY: begin
            state_d = scc_pkg::ST_SEARCH;
          end
          default: begin
          end
        endcase
      end

      scc_pkg::ST_ALU: begin
        case (mode_q)
          scc_pkg::MODE_ADD: res_d = top_q + alu_b;
          scc_pkg::MODE_SUB: res_d = top_q - alu_b;
          default:           res_d = DW'(top_q * alu_b);
        endcase
        state_d = scc_pkg::ST_ARITH_WB;
      end

      scc_pkg::ST_ARITH_WB: begin
        stk_we    = 1'b1;
        stk_waddr = two_q ? sp_m2 : '0;
        stk_wdata = res_q;
        top_d     = res_q;
        sp_d      = two_q ? (sp_q - SP_W'(1)) : sp_q;
        state_d   = scc_pkg::ST_DONE;
      end

      scc_pkg::ST_SEARCH: begin
        // one key read per cycle; each compare comes in the cycle after its read
        if (cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata == key_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          state_d   = scc_pkg::ST_HIT;
        end else if (cmp_vld_q && (cmp_idx_q == IDX_LAST)) begin
          hit_d   = 1'b0;
          state_d = scc_pkg::ST_HIT;
        end else begin
          cmp_idx_d = scan_q;
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + IDX_W'(1);
        end
      end

      scc_pkg::ST_HIT: begin
        state_d   = scc_pkg::ST_DONE;
        tbl_raddr = hit_idx_q;   // value read for read and query
        case (mode_q)
          scc_pkg::MODE_WRITE: begin
            if (hit_q) begin
              tbl_we   = 1'b1;
              tbl_wval = (sp_q == '0) ? '0 : top_q;
            end
            if (sp_q != '0) begin
              sp_d = sp_q - SP_W'(1);
              if (sp_q > SP_W'(1)) begin
                state_d = scc_pkg::ST_TOP_LOAD;   // fetch the new top
              end
            end
          end
          scc_pkg::MODE_READ: begin
            if (hit_q) begin
              if (sp_q == SP_FULL) begin
                ovf_d = 1'b1;
              end else begin
                state_d = scc_pkg::ST_PUSH_VAR;
              end
            end
          end
          scc_pkg::MODE_ASSIGN: begin
            if (hit_q) begin
              tbl_we = 1'b1;
            end else if (free_any) begin
              tbl_we            = 1'b1;
              tbl_new           = 1'b1;
              tbl_waddr         = free_idx;
              valid_d[free_idx] = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          scc_pkg::MODE_QUERY: begin
            if (hit_q) begin
              state_d = scc_pkg::ST_QUERY;
            end
          end
          default: begin
          end
        endcase
      end

      scc_pkg::ST_TOP_LOAD: begin
        top_d   = stk_rdata;
        state_d = scc_pkg::ST_DONE;
      end

      scc_pkg::ST_PUSH_VAR: begin
        stk_we    = 1'b1;
        stk_wdata = val_rdata;
        top_d     = val_rdata;
        sp_d      = sp_q + SP_W'(1);
        state_d   = scc_pkg::ST_DONE;
      end

      scc_pkg::ST_QUERY: begin
        query_d = val_rdata;
        state_d = scc_pkg::ST_DONE;
      end

      scc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_top_d    = (sp_q == '0) ? '0 : top_q;
          out_depth_d  = DEPTH_W_L'(sp_q);
          out_query_d  = query_q;
          out_call_d   = call_q;
          out_target_d = call_q ? scc_pkg::NAME_W'(key_q) : '0;
          out_ovf_d    = ovf_q;
          state_d      = scc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = scc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scc_pkg::ST_IDLE;
      sp_q        <= '0;
      valid_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      valid_q     <= valid_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    opnd_q       <= opnd_d;
    top_q        <= top_d;
    res_q        <= res_d;
    two_q        <= two_d;
    scan_q       <= scan_d;
    cmp_idx_q    <= cmp_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    query_q      <= query_d;
    call_q       <= call_d;
    ovf_q        <= ovf_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_query_q  <= out_query_d;
    out_call_q   <= out_call_d;
    out_target_q <= out_target_d;
    out_ovf_q    <= out_ovf_d;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_ready_o      = (state_q == scc_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign top_value_o     = out_top_q;
  assign depth_now_o     = out_depth_q;
  assign query_value_o   = out_query_q;
  assign call_request_o  = out_call_q;
  assign call_target_o   = out_target_q;
  assign overflow_flag_o = out_ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  a_new_key_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_new |-> !valid_q[tbl_waddr])
    else $error("new key written over a live table entry");

  a_search_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scc_pkg::ST_SEARCH) |->
      (mode_q == scc_pkg::MODE_WRITE) || (mode_q == scc_pkg::MODE_READ) ||
      (mode_q == scc_pkg::MODE_ASSIGN) || (mode_q == scc_pkg::MODE_QUERY))
    else $error("table search for a mode without a lookup");

  a_target_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !call_request_o) |-> (call_target_o == '0))
    else $error("call target set without a call request");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for stack_calculator_core_unit: a directed instruction table,
// then weighted random streams, scored against an in-bench predictor or typed-in results.
// Depends on scc_pkg (widths, sizes, mode codes) and the RTL of the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // codes 10..15 are not decoded by the core and act as no-ops
  localparam logic [scc_pkg::MODE_W-1:0] MODE_NOP_FIRST = 4'd10;
  localparam logic [scc_pkg::MODE_W-1:0] MODE_NOP_LAST  = 4'd15;

  localparam logic [scc_pkg::NAME_W-1:0] KEY_MASK =
    scc_pkg::NAME_W'((64'd1 << scc_pkg::KEY_BITS) - 1);

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;   // long output stall
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any accepted word
  localparam int unsigned DRAIN_CYCLES = 2 * (scc_pkg::TABLE_ENTRIES + 5);

  typedef struct packed {
    logic signed [scc_pkg::DATA_W-1:0]  top;
    logic        [scc_pkg::DEPTH_W-1:0] depth;
    logic signed [scc_pkg::DATA_W-1:0]  qv;
    logic                               call;
    logic        [scc_pkg::NAME_W-1:0]  tgt;
    logic                               ovf;
  } calc_result_t;

  // one row of the directed table; rep k uses key + k and operand + k
  typedef struct packed {
    logic [scc_pkg::MODE_W-1:0] mode;
    logic [scc_pkg::NAME_W-1:0] key;
    logic [scc_pkg::DATA_W-1:0] opnd;
    int                         reps;
    bit                         fixed;   // use the typed-in result instead of the predictor
    calc_result_t               want;
  } stim_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic        [scc_pkg::MODE_W-1:0]   mode_i;
  logic        [scc_pkg::NAME_W-1:0]   name_key_i;
  logic signed [scc_pkg::DATA_W-1:0]   operand_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [scc_pkg::DATA_W-1:0]   top_value_o;
  logic        [scc_pkg::DEPTH_W-1:0]  depth_now_o;
  logic signed [scc_pkg::DATA_W-1:0]   query_value_o;
  logic                                call_request_o;
  logic        [scc_pkg::NAME_W-1:0]   call_target_o;
  logic                                overflow_flag_o;

  stack_calculator_core_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .name_key_i     (name_key_i),
    .operand_i      (operand_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_value_o    (top_value_o),
    .depth_now_o    (depth_now_o),
    .query_value_o  (query_value_o),
    .call_request_o (call_request_o),
    .call_target_o  (call_target_o),
    .overflow_flag_o(overflow_flag_o)
  );

  // predictor state: stack plus variable table
  logic [scc_pkg::DATA_W-1:0] stk      [scc_pkg::STACK_DEPTH];
  int unsigned                stk_ptr;
  logic [scc_pkg::NAME_W-1:0] var_key  [scc_pkg::TABLE_ENTRIES];
  logic [scc_pkg::DATA_W-1:0] var_val  [scc_pkg::TABLE_ENTRIES];
  bit                         var_used [scc_pkg::TABLE_ENTRIES];

  calc_result_t               pending_results[$];
  stim_row_t                  stim_rows[$];
  logic [scc_pkg::NAME_W-1:0] key_pool[$];
  calc_result_t               no_result = '0;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned stall_cycles;
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_ovf;
  int unsigned n_calls;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int find_var(logic [scc_pkg::NAME_W-1:0] key);
    for (int i = 0; i < scc_pkg::TABLE_ENTRIES; i++)
      if (var_used[i] && var_key[i] == key) return i;
    return -1;
  endfunction

  // Executes one instruction on the predictor state and returns the result word.
  function automatic calc_result_t exec_instruction(logic [scc_pkg::MODE_W-1:0] mode,
                                                    logic [scc_pkg::NAME_W-1:0] name,
                                                    logic [scc_pkg::DATA_W-1:0] opnd);
    calc_result_t               r;
    logic [scc_pkg::DATA_W-1:0] a;
    logic [scc_pkg::DATA_W-1:0] b;
    logic [scc_pkg::DATA_W-1:0] v;
    logic [scc_pkg::NAME_W-1:0] key;
    int                         idx;
    r   = '0;
    key = name & KEY_MASK;
    case (mode)
      scc_pkg::MODE_PUSH: begin
        if (stk_ptr >= scc_pkg::STACK_DEPTH) r.ovf = 1'b1;
        else begin
          stk[stk_ptr] = opnd;
          stk_ptr++;
        end
      end
      scc_pkg::MODE_ADD, scc_pkg::MODE_SUB, scc_pkg::MODE_MUL: begin
        if (stk_ptr == 0) begin
          // empty stack: result is a pushed zero
          stk[0]  = '0;
          stk_ptr = 1;
        end else begin
          stk_ptr--;
          a = stk[stk_ptr];
          // lone operand pairs with 0, or 1 for mul
          if (stk_ptr > 0) begin
            stk_ptr--;
            b = stk[stk_ptr];
          end else begin
            b = (mode == scc_pkg::MODE_MUL) ? 32'd1 : 32'd0;
          end
          if (mode == scc_pkg::MODE_ADD)      v = a + b;
          else if (mode == scc_pkg::MODE_SUB) v = a - b;
          else                                v = a * b;
          stk[stk_ptr] = v;
          stk_ptr++;
        end
      end
      scc_pkg::MODE_WRITE: begin
        // empty stack writes 0 and stays empty
        a = '0;
        if (stk_ptr > 0) begin
          stk_ptr--;
          a = stk[stk_ptr];
        end
        idx = find_var(key);
        if (idx >= 0) var_val[idx] = a;
      end
      scc_pkg::MODE_READ: begin
        idx = find_var(key);
        if (idx >= 0) begin
          if (stk_ptr >= scc_pkg::STACK_DEPTH) r.ovf = 1'b1;
          else begin
            stk[stk_ptr] = var_val[idx];
            stk_ptr++;
          end
        end
      end
      scc_pkg::MODE_JUMP: r.call = 1'b1;
      scc_pkg::MODE_JUMPZ: begin
        // no pop here
        if (stk_ptr == 0 || stk[stk_ptr-1] == 0) r.call = 1'b1;
      end
      scc_pkg::MODE_ASSIGN: begin
        idx = find_var(key);
        if (idx < 0) begin
          for (int i = 0; i < scc_pkg::TABLE_ENTRIES; i++)
            if (!var_used[i]) begin
              idx = i;
              break;
            end
        end
        if (idx >= 0) begin
          var_used[idx] = 1'b1;
          var_key[idx]  = key;
          var_val[idx]  = opnd;
        end else begin
          r.ovf = 1'b1;
        end
      end
      scc_pkg::MODE_QUERY: begin
        idx = find_var(key);
        if (idx >= 0) r.qv = var_val[idx];
      end
      default: ;
    endcase
    if (r.call) r.tgt = key;
    r.top   = (stk_ptr == 0) ? '0 : stk[stk_ptr-1];
    r.depth = scc_pkg::DEPTH_W'(stk_ptr);
    return r;
  endfunction

  function automatic calc_result_t mk_result(logic [scc_pkg::DATA_W-1:0] top,
                                             int unsigned depth,
                                             logic [scc_pkg::DATA_W-1:0] qv, logic call,
                                             logic [scc_pkg::NAME_W-1:0] tgt, logic ovf);
    calc_result_t r;
    r.top   = top;
    r.depth = scc_pkg::DEPTH_W'(depth);
    r.qv    = qv;
    r.call  = call;
    r.tgt   = tgt;
    r.ovf   = ovf;
    return r;
  endfunction

  function automatic void add_row(logic [scc_pkg::MODE_W-1:0] mode,
                                  logic [scc_pkg::NAME_W-1:0] key,
                                  logic [scc_pkg::DATA_W-1:0] opnd, int reps, bit fixed,
                                  calc_result_t want);
    stim_row_t row;
    row.mode  = mode;
    row.key   = key;
    row.opnd  = opnd;
    row.reps  = reps;
    row.fixed = fixed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // push_pct high lets the stack grow toward full, low drains it
  function automatic logic [scc_pkg::MODE_W-1:0] pick_mode(int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(99) < push_pct) return scc_pkg::MODE_PUSH;
    r = $urandom_range(99);
    if (r < 12) return scc_pkg::MODE_ADD;
    if (r < 24) return scc_pkg::MODE_SUB;
    if (r < 34) return scc_pkg::MODE_MUL;
    if (r < 46) return scc_pkg::MODE_WRITE;
    if (r < 60) return scc_pkg::MODE_READ;
    if (r < 68) return scc_pkg::MODE_JUMP;
    if (r < 78) return scc_pkg::MODE_JUMPZ;
    if (r < 88) return scc_pkg::MODE_ASSIGN;
    if (r < 96) return scc_pkg::MODE_QUERY;
    return scc_pkg::MODE_W'($urandom_range(MODE_NOP_LAST, MODE_NOP_FIRST));
  endfunction

  // mostly keys the table knows (or a few it never will), else any key
  function automatic logic [scc_pkg::NAME_W-1:0] pick_key();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(key_pool.size() - 1)];
    return scc_pkg::NAME_W'($urandom);
  endfunction

  function automatic logic [scc_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(4))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void check_field(string what, logic [scc_pkg::DATA_W-1:0] want,
                                      logic [scc_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch on result word %0d: expected %0h, actual %0h",
               $time, what, n_results, want, got);
      errors++;
    end
  endfunction

  // Drives one instruction word and holds it until accepted; the predictor runs at
  // the accepting edge.
  task automatic send_word(logic [scc_pkg::MODE_W-1:0] mode,
                           logic [scc_pkg::NAME_W-1:0] key,
                           logic [scc_pkg::DATA_W-1:0] opnd, bit fixed, calc_result_t want);
    calc_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    name_key_i <= key;
    operand_i  <= opnd;
    do @(posedge clk_i); while (!in_ready_o);
    pred = exec_instruction(mode, key, opnd);
    pending_results.insert(pending_results.size(), fixed ? want : pred);
    n_sent++;
  endtask

  // receiver: random ready, or a long counted hold-off when requested
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result scoreboard and watchdog
  always @(posedge clk_i) begin
    calc_result_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no word accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with no pending expectation (top %0h depth %0d)",
                 $time, top_value_o, depth_now_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("top_value",     want.top,   top_value_o);
        check_field("depth_now",     want.depth, depth_now_o);
        check_field("query_value",   want.qv,    query_value_o);
        check_field("call_request",  want.call,  call_request_o);
        check_field("call_target",   want.tgt,   call_target_o);
        check_field("overflow_flag", want.ovf,   overflow_flag_o);
        if (want.ovf)  n_ovf++;
        if (want.call) n_calls++;
      end
    end
  end

  initial begin
    int                         unsigned push_pct;
    logic [scc_pkg::MODE_W-1:0] mode;
    stim_row_t                  row;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= '0;
    name_key_i <= '0;
    operand_i  <= '0;
    stk_ptr       = 0;
    hold_req      = 1'b0;
    stall_cycles  = 0;
    errors        = 0;
    n_sent        = 0;
    n_results     = 0;
    n_ovf         = 0;
    n_calls       = 0;
    send_idle_pct = 10;
    recv_idle_pct = 72;
    for (int i = 0; i < scc_pkg::TABLE_ENTRIES; i++) var_used[i] = 1'b0;

    // directed table; typed results only where they follow from reset state at a glance
    add_row(scc_pkg::MODE_QUERY,  16'h0000, 32'h0000_0000, 1, 1,
            mk_result(0, 0, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_ADD,    16'h0000, 32'h0000_0000, 1, 1,
            mk_result(0, 1, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_WRITE,  16'h0005, 32'h0000_0000, 1, 1,
            mk_result(0, 0, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_WRITE,  16'h0005, 32'hFFFF_FFFF, 1, 1,
            mk_result(0, 0, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_JUMPZ,  16'hFFFF, 32'h0000_0000, 1, 1,
            mk_result(0, 0, 0, 1, 16'hFFFF, 0));
    add_row(scc_pkg::MODE_JUMP,   16'hA5A5, 32'h0000_0000, 1, 1,
            mk_result(0, 0, 0, 1, 16'hA5A5, 0));
    add_row(MODE_NOP_LAST, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, mk_result(0, 0, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_PUSH,   16'h0000, 32'h7FFF_FFFF, 1, 1,
            mk_result(32'h7FFF_FFFF, 1, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_PUSH,   16'hFFFF, 32'h8000_0000, 1, 1,
            mk_result(32'h8000_0000, 2, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_ADD,    16'h0000, 32'h0000_0000, 1, 1,
            mk_result(32'hFFFF_FFFF, 1, 0, 0, 0, 0));
    add_row(scc_pkg::MODE_SUB,    16'h0000, 32'h0000_0000, 1, 0, no_result);  // lone operand
    add_row(scc_pkg::MODE_MUL,    16'h0000, 32'h0000_0000, 1, 0, no_result);  // lone, x1
    add_row(scc_pkg::MODE_PUSH,   16'h0000, 32'h0000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_JUMPZ,  16'h1234, 32'h0000_0000, 1, 0, no_result);  // zero top
    add_row(scc_pkg::MODE_MUL,    16'h0000, 32'h0000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_PUSH,   16'h0000, 32'hFFFF_FFFF, 1, 0, no_result);
    add_row(scc_pkg::MODE_SUB,    16'h0000, 32'h0000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_JUMPZ,  16'h4321, 32'h0000_0000, 1, 0, no_result);  // nonzero top
    add_row(scc_pkg::MODE_ASSIGN, 16'hFFFF, 32'h8000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_QUERY,  16'hFFFF, 32'h0000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_READ,   16'hFFFF, 32'h0000_0000, 1, 0, no_result);
    add_row(scc_pkg::MODE_READ,   16'h1234, 32'h0000_0000, 1, 0, no_result);  // absent var
    add_row(scc_pkg::MODE_WRITE,  16'hFFFF, 32'h0000_0000, 1, 0, no_result);
    add_row(MODE_NOP_FIRST, 16'h0000, 32'h0000_0000, 1, 0, no_result);
    // runs into full stack
    add_row(scc_pkg::MODE_PUSH,   16'h0000, 32'h5A5A_5A5A, 16, 0, no_result);
    // full stack, present variable
    add_row(scc_pkg::MODE_READ,   16'hFFFF, 32'h0000_0000, 1, 0, no_result);
    // fills the table
    add_row(scc_pkg::MODE_ASSIGN, 16'h0100, 32'h1111_0000, 16, 0, no_result);
    // full table: new key, then an update
    add_row(scc_pkg::MODE_ASSIGN, 16'h0000, 32'h2222_2222, 1, 0, no_result);
    add_row(scc_pkg::MODE_ASSIGN, 16'hFFFF, 32'h7FFF_FFFF, 1, 0, no_result);
    add_row(scc_pkg::MODE_MUL,    16'h0000, 32'h0000_0000, 1, 0, no_result);  // two operands

    // keys present in the table after the directed part, plus a few absent ones
    key_pool.insert(key_pool.size(), 16'hFFFF);
    for (int i = 0; i < scc_pkg::TABLE_ENTRIES - 1; i++)
      key_pool.insert(key_pool.size(), 16'h0100 + scc_pkg::NAME_W'(i));
    key_pool.insert(key_pool.size(), 16'h010F);
    key_pool.insert(key_pool.size(), 16'h0000);
    key_pool.insert(key_pool.size(), 16'h1234);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r]) begin
      row = stim_rows[r];
      for (int k = 0; k < row.reps; k++)
        send_word(row.mode, row.key + scc_pkg::NAME_W'(k),
                  row.opnd + scc_pkg::DATA_W'(k), row.fixed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 10;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // output stalls for a long stretch while words keep coming
      if (n == 200) hold_req = 1'b1;
      // let the core drain completely before going on
      if (n == 900) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      // alternate growing and draining stretches of the stack
      push_pct = ((n / 40) % 2 == 0) ? 45 : 10;
      mode = pick_mode(push_pct);
      send_word(mode, pick_key(), pick_value(), 1'b0, no_result);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d instruction words and %0d result words: all modes, unused codes,",
             n_sent, n_results);
    $display("full stack and table (%0d drops), %0d call requests, three idling mixes and stalls.",
             n_ovf, n_calls);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: stack_calculator_core_unit.f
hdl/scc_pkg.sv
hdl/scc_ram.sv
hdl/stack_calculator_core_unit.sv
tb/tb_top.sv
